[rtl/lcdseq_pkg.sv]
package lcdseq_pkg;

  // display geometry
  localparam int COLUMNS = 16;

  localparam int TICK_W    = 24;
  localparam int CFG_IDX_W = 3;

  // request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // glyph rows carried by one request
  localparam int GLYPH_ROWS = 8;
  localparam int BCNT_W     = $clog2(GLYPH_ROWS + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STROBE_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_GAP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WAIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WAIT  = 3'd4;

  localparam logic [TICK_W-1:0] RST_STROBE_HIGH = 24'd50;
  localparam logic [TICK_W-1:0] RST_NIBBLE_GAP  = 24'd10000;
  localparam logic [TICK_W-1:0] RST_BYTE_GAP    = 24'd100000;
  localparam logic [TICK_W-1:0] RST_CLEAR_WAIT  = 24'd1000000;
  localparam logic [TICK_W-1:0] RST_GLYPH_WAIT  = 24'd500000;

  // controller command bytes
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_ROW0_ADDR = 8'h80;
  localparam logic [7:0] CMD_ROW1_ADDR = 8'hC0;
  localparam logic [7:0] CMD_CGRAM     = 8'h40;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  typedef enum logic [2:0] {
    FUNC_CMD     = 3'd0,
    FUNC_DATA    = 3'd1,
    FUNC_CURSOR  = 3'd2,
    FUNC_CHAR_AT = 3'd3,
    FUNC_CLEAR   = 3'd4,
    FUNC_GLYPH   = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    WAIT_NONE  = 2'd0,
    WAIT_CLEAR = 2'd1,
    WAIT_GLYPH = 2'd2
  } wait_sel_t;

  // four bus phases of one byte
  typedef enum logic [1:0] {
    PH_HI_ON  = 2'd0,
    PH_HI_OFF = 2'd1,
    PH_LO_ON  = 2'd2,
    PH_LO_OFF = 2'd3
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] strobe_high;
    logic [TICK_W-1:0] nibble_gap;
    logic [TICK_W-1:0] byte_gap;
    logic [TICK_W-1:0] clear_wait;
    logic [TICK_W-1:0] glyph_wait;
  } cfg_t;

  // one classified request: a lead byte, optional extra wait, then body bytes
  typedef struct packed {
    logic [7:0]              first_byte;
    logic                    first_rs;
    wait_sel_t               wait_sel;
    logic [BCNT_W-1:0]       body_cnt;
    logic                    body_rs;
    logic [8*GLYPH_ROWS-1:0] body;
  } job_t;

  // one bus phase
  typedef struct packed {
    logic [3:0]        nibble;
    logic              rs;
    logic              en;
    logic [TICK_W-1:0] hold;
    logic              last;
  } phase_out_t;

endpackage

[rtl/lcdseq_front.sv]
module lcdseq_front (
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [87:0]         in_tdata,
  input  logic [2:0]          in_tuser,
  input  logic                q_full,
  output logic                push,
  output lcdseq_pkg::job_t    push_job
);
  import lcdseq_pkg::*;

  logic [7:0]  byte_value;
  logic [1:0]  row;
  logic [4:0]  pos;
  logic [3:0]  slot;
  logic [63:0] rows;
  logic        cur_ok;
  logic [7:0]  cur_cmd;
  logic        job_ok;

  assign byte_value = in_tdata[7:0];
  assign row        = in_tdata[9:8];
  assign pos        = in_tdata[14:10];
  assign slot       = in_tdata[18:15];
  assign rows       = in_tdata[82:19];

  assign in_tready = !q_full;

  // cursor address command; rows above 1 or columns past the edge are invalid
  always_comb begin
    cur_ok  = (32'(pos) < COLUMNS) && (row[1] == 1'b0);
    cur_cmd = (row[0] ? CMD_ROW1_ADDR : CMD_ROW0_ADDR) | {4'h0, pos[3:0]};
  end

  always_comb begin
    job_ok              = 1'b0;
    push_job.first_byte = byte_value;
    push_job.first_rs   = RS_CMD;
    push_job.wait_sel   = WAIT_NONE;
    push_job.body_cnt   = '0;
    push_job.body_rs    = RS_DATA;
    push_job.body       = {56'h0, byte_value};
    unique case (func_t'(in_tuser))
      FUNC_CMD: begin
        job_ok = 1'b1;
      end
      FUNC_DATA: begin
        job_ok            = 1'b1;
        push_job.first_rs = RS_DATA;
      end
      FUNC_CURSOR: begin
        job_ok              = cur_ok;
        push_job.first_byte = cur_cmd;
      end
      FUNC_CHAR_AT: begin
        job_ok = 1'b1;
        if (cur_ok) begin
          push_job.first_byte = cur_cmd;
          push_job.body_cnt   = BCNT_W'(1);
        end else begin
          push_job.first_rs = RS_DATA;
        end
      end
      FUNC_CLEAR: begin
        job_ok              = 1'b1;
        push_job.first_byte = CMD_CLEAR;
        push_job.wait_sel   = WAIT_CLEAR;
        push_job.body_cnt   = BCNT_W'(1);
        push_job.body_rs    = RS_CMD;
        push_job.body       = {56'h0, CMD_ROW0_ADDR};
      end
      FUNC_GLYPH: begin
        job_ok              = (slot[3] == 1'b0);
        push_job.first_byte = CMD_CGRAM + {2'b00, slot[2:0], 3'b000};
        push_job.wait_sel   = WAIT_GLYPH;
        push_job.body_cnt   = BCNT_W'(GLYPH_ROWS);
        push_job.body       = rows;
      end
      default: begin
        job_ok = 1'b0;
      end
    endcase
  end

  // rejected requests are consumed without output
  assign push = in_tvalid && in_tready && job_ok;

endmodule

[rtl/lcdseq_queue.sv]
module lcdseq_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lcdseq_pkg::job_t    push_job,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output lcdseq_pkg::job_t    head_job
);
  import lcdseq_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign full       = (count_r == (QAW+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[rtl/lcdseq_back.sv]
module lcdseq_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcdseq_pkg::cfg_t      cfg,
  input  logic                  head_valid,
  input  lcdseq_pkg::job_t      head_job,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output lcdseq_pkg::phase_out_t out_phase
);
  import lcdseq_pkg::*;

  phase_t            ph_r, ph_nxt;
  logic [BCNT_W-1:0] bidx_r, bidx_nxt;
  logic              wait_r, wait_nxt;
  logic              out_valid_r, out_valid_nxt;
  phase_out_t        out_r, out_nxt;

  logic              adv;
  logic [2:0]        body_sel;
  logic [7:0]        cur_byte;
  logic              cur_rs;
  logic              byte_done;
  logic              wait_next;

  // output register takes a new phase when empty or being drained
  assign adv = head_valid && (!out_valid_r || out_tready);

  assign body_sel = 3'(bidx_r - 1'b1);

  always_comb begin
    if (bidx_r == '0) begin
      cur_byte = head_job.first_byte;
      cur_rs   = head_job.first_rs;
    end else begin
      cur_byte = head_job.body[{body_sel, 3'b000} +: 8];
      cur_rs   = head_job.body_rs;
    end
  end

  assign byte_done = (ph_r == PH_LO_OFF);
  assign wait_next = (bidx_r == '0) && (head_job.wait_sel != WAIT_NONE);

  always_comb begin
    ph_nxt        = ph_r;
    bidx_nxt      = bidx_r;
    wait_nxt      = wait_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    pop           = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (adv) begin
      out_valid_nxt = 1'b1;
      if (wait_r) begin
        // extra wait repeats the low-nibble, strobe-low pin state
        out_nxt.nibble = head_job.first_byte[3:0];
        out_nxt.rs     = head_job.first_rs;
        out_nxt.en     = 1'b0;
        out_nxt.hold   = (head_job.wait_sel == WAIT_CLEAR) ? cfg.clear_wait
                                                           : cfg.glyph_wait;
        out_nxt.last   = (head_job.body_cnt == '0);
        wait_nxt       = 1'b0;
        ph_nxt         = PH_HI_ON;
        if (head_job.body_cnt == '0) begin
          pop      = 1'b1;
          bidx_nxt = '0;
        end else begin
          bidx_nxt = BCNT_W'(1);
        end
      end else begin
        out_nxt.nibble = ph_r[1] ? cur_byte[3:0] : cur_byte[7:4];
        out_nxt.rs     = cur_rs;
        out_nxt.en     = !ph_r[0];
        unique case (ph_r)
          PH_HI_ON:  out_nxt.hold = cfg.strobe_high;
          PH_HI_OFF: out_nxt.hold = cfg.nibble_gap;
          PH_LO_ON:  out_nxt.hold = cfg.strobe_high;
          PH_LO_OFF: out_nxt.hold = cfg.byte_gap;
          default:   out_nxt.hold = cfg.byte_gap;
        endcase
        out_nxt.last = byte_done && !wait_next && (bidx_r == head_job.body_cnt);
        ph_nxt       = phase_t'(ph_r + 2'd1);
        if (byte_done) begin
          if (wait_next) begin
            wait_nxt = 1'b1;
          end else if (bidx_r == head_job.body_cnt) begin
            pop      = 1'b1;
            bidx_nxt = '0;
          end else begin
            bidx_nxt = bidx_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_HI_ON;
      bidx_r      <= '0;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      bidx_r      <= bidx_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_phase  = out_r;

endmodule

[rtl/char_lcd_nibble_write_sequencer_top.sv]
// First phase: with the back end idle, a taken request is written into the request queue, then
//   its first bus phase is registered onto out_*; requests that produce no phase are taken and dropped.
// Throughput: one phase per cycle unless out_tready is low; a request occupies the back end for 4 phases (command,
//   char, cursor, char at a bad position), 8 (char at position), 9 (clear) or 37 (glyph).
// Reset (rst_n low, synchronous): timing registers return to their power-on values,
//   the two-deep request queue empties and any phase in flight is dropped.
module char_lcd_nibble_write_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,

  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // byte_value[7:0], row[9:8], pos[14:10], glyph_slot[18:15], glyph_rows[82:19]
  input  logic [87:0] in_tdata,
  // func[2:0]
  input  logic [2:0]  in_tuser,

  // bus phase channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // data_nibble[3:0], enable[4], hold_ticks[28:5]
  output logic [31:0] out_tdata,
  // reg_select[0]
  output logic        out_tuser,
  output logic        out_tlast,

  // timing register writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  import lcdseq_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       q_full;
  logic       push;
  job_t       push_job;
  logic       pop;
  logic       head_valid;
  job_t       head_job;
  phase_out_t out_phase;

  // Timing registers: written by index, unknown indexes ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_STROBE_HIGH: cfg_nxt.strobe_high = cfg_wdata;
        CFG_NIBBLE_GAP:  cfg_nxt.nibble_gap  = cfg_wdata;
        CFG_BYTE_GAP:    cfg_nxt.byte_gap    = cfg_wdata;
        CFG_CLEAR_WAIT:  cfg_nxt.clear_wait  = cfg_wdata;
        CFG_GLYPH_WAIT:  cfg_nxt.glyph_wait  = cfg_wdata;
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.strobe_high <= RST_STROBE_HIGH;
      cfg_r.nibble_gap  <= RST_NIBBLE_GAP;
      cfg_r.byte_gap    <= RST_BYTE_GAP;
      cfg_r.clear_wait  <= RST_CLEAR_WAIT;
      cfg_r.glyph_wait  <= RST_GLYPH_WAIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: decode the request into a lead byte, optional wait and body bytes.
  // Requests that produce nothing (bad cursor, bad slot, unused func) are
  // accepted and dropped here.
  lcdseq_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  lcdseq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back: walks nibble phases of the head job, one per cycle while out_tready
  // allows, into an output register; the job is popped with its final phase.
  lcdseq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_phase  (out_phase)
  );

  assign out_tdata = {3'b000, out_phase.hold, out_phase.en, out_phase.nibble};
  assign out_tuser = out_phase.rs;
  assign out_tlast = out_phase.last;

endmodule
